FILE: sv/lpp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes, reset values and types of the Lissajous point projector.
// Depends on nothing; every other file of the block uses it.
package lpp_pkg;

   localparam int ANGLE_BITS_DEF  = 16;
   localparam int SCREEN_BITS_DEF = 12;

   localparam int SAMPLE_BITS    = 17;
   localparam int OUT_BITS       = 16;
   localparam int TRIG_BITS      = 16;
   localparam int CRD_BITS       = 24;   // signed Q.8 coordinate
   localparam int DEN_BITS       = 24;   // positive perspective denominator
   localparam int CSR_DATA_BITS  = 48;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FREQUENCIES = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASES      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROTATIONS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AMPLITUDES  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DISTANCE    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WIDTH       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEIGHT      = 3'd6;

   localparam logic [47:0] FREQ_RST  = 48'd57725199331200;
   localparam logic [31:0] PHASE_RST = 32'd1073774592;
   localparam logic [47:0] ROT_RST   = 48'd223994552254464;
   localparam logic [35:0] AMP_RST   = 36'd3876725126;
   localparam logic [14:0] DIST_RST  = 15'd1800;
   localparam int          WIDTH_RST  = 800;
   localparam int          HEIGHT_RST = 600;

   // 2^32 / (2*pi), and the sine polynomial coefficients (Q.22 domain)
   localparam logic [29:0] INV2PI      = 30'd683565276;
   localparam logic [22:0] QUARTER_Q22 = 23'd4194304;
   localparam logic [30:0] K1          = 31'd1686629713;
   localparam logic [29:0] K3          = 30'd693598668;
   localparam logic [26:0] K5          = 27'd85569306;
   localparam logic [22:0] K7          = 23'd5026995;

   typedef struct packed {
      logic valid;
      logic behind;
      logic neg_x;
      logic neg_y;
   } div_ctl_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] screen_x;
      logic signed [OUT_BITS-1:0] screen_y;
      logic                       behind_viewer;
   } rsp_payload_type;

endpackage

FILE: sv/lpp_req_if.sv
`timescale 1ns / 1ps
// Request channel: one curve time sample per transfer.
// Depends on lpp_pkg.
interface lpp_req_if;
   logic                               valid;
   logic                               ready;
   logic [lpp_pkg::SAMPLE_BITS-1:0]    sample_time;

   modport source (output valid, output sample_time, input ready);
   modport sink   (input valid, input sample_time, output ready);
endinterface

FILE: sv/lpp_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: one projected screen point per transfer.
// Depends on lpp_pkg.
interface lpp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lpp_pkg::OUT_BITS-1:0] screen_x;
   logic signed [lpp_pkg::OUT_BITS-1:0] screen_y;
   logic                                behind_viewer;

   modport source (output valid, output screen_x, output screen_y, output behind_viewer,
                   input ready);
   modport sink   (input valid, input screen_x, input screen_y, input behind_viewer,
                   output ready);
endinterface

FILE: sv/lpp_sin.sv
`timescale 1ns / 1ps
// Six-stage pipelined Q1.15 sine of a turn fraction, odd polynomial in Horner form.
// Depends on lpp_pkg.
module lpp_sin #(
   parameter int ANGLE_BITS = lpp_pkg::ANGLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [ANGLE_BITS-1:0]                angle,
   output logic signed [lpp_pkg::TRIG_BITS-1:0] sin_q15
);

   logic [23:0] a24;
   logic [22:0] u_fold;
   logic [22:0] u2;
   logic [26:0] p5;
   logic [29:0] p3;
   logic [30:0] p1;
   logic [31:0] pp;
   logic [16:0] r17;
   logic [14:0] mag;

   logic [45:0] sq_ff, sq_in;
   logic [45:0] m7_ff, m7_in;
   logic [49:0] m5_ff, m5_in;
   logic [52:0] m3_ff, m3_in;
   logic [53:0] m1_ff, m1_in;
   logic [22:0] u_ff  [4];
   logic [22:0] u2_ff [2];
   logic [1:0]  q_ff  [5];
   logic signed [lpp_pkg::TRIG_BITS-1:0] out_ff, out_in;

   assign a24    = 24'(angle) << (24 - ANGLE_BITS);
   // fold the odd quadrants back onto the rising quarter
   assign u_fold = a24[22] ? (lpp_pkg::QUARTER_Q22 - {1'b0, a24[21:0]}) : {1'b0, a24[21:0]};

   assign u2    = sq_ff[44:22];
   assign sq_in = 46'(u_fold) * 46'(u_fold);
   assign m7_in = 46'(lpp_pkg::K7) * 46'(u2);
   assign p5    = lpp_pkg::K5 - 27'(m7_ff >> 22);
   assign m5_in = 50'(p5) * 50'(u2_ff[0]);
   assign p3    = lpp_pkg::K3 - 30'(m5_ff >> 22);
   assign m3_in = 53'(p3) * 53'(u2_ff[1]);
   assign p1    = lpp_pkg::K1 - 31'(m3_ff >> 22);
   assign m1_in = 54'(p1) * 54'(u_ff[3]);

   always_comb begin
      pp  = m1_ff[53:22];
      r17 = 17'((33'(pp) + 33'd16384) >> 15);
      mag = (r17 > 17'd32767) ? 15'h7FFF : r17[14:0];
      out_in = q_ff[4][1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_in;
         u_ff[0]  <= u_fold;
         q_ff[0]  <= a24[23:22];
         m7_ff    <= m7_in;
         u2_ff[0] <= u2;
         u_ff[1]  <= u_ff[0];
         q_ff[1]  <= q_ff[0];
         m5_ff    <= m5_in;
         u2_ff[1] <= u2_ff[0];
         u_ff[2]  <= u_ff[1];
         q_ff[2]  <= q_ff[1];
         m3_ff    <= m3_in;
         u_ff[3]  <= u_ff[2];
         q_ff[3]  <= q_ff[2];
         m1_ff    <= m1_in;
         q_ff[4]  <= q_ff[3];
         out_ff   <= out_in;
      end
   end

   assign sin_q15 = out_ff;

endmodule

FILE: sv/lpp_rotate.sv
`timescale 1ns / 1ps
// Two-stage plane rotation: products, then rounded sums (Q.15 trig, half-up rounding).
// Depends on lpp_pkg.
module lpp_rotate (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [lpp_pkg::TRIG_BITS-1:0] cos_v,
   input  logic signed [lpp_pkg::TRIG_BITS-1:0] sin_v,
   input  logic signed [lpp_pkg::CRD_BITS-1:0]  a,
   input  logic signed [lpp_pkg::CRD_BITS-1:0]  b,
   output logic signed [lpp_pkg::CRD_BITS-1:0]  a_rot,  // a*c - b*s
   output logic signed [lpp_pkg::CRD_BITS-1:0]  b_rot   // a*s + b*c
);

   localparam int PW = lpp_pkg::CRD_BITS + lpp_pkg::TRIG_BITS;

   logic signed [PW-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [PW-1:0] ac_in, bs_in, as_in, bc_in;
   logic signed [PW:0]   sum_a, sum_b;
   logic signed [lpp_pkg::CRD_BITS-1:0] a_ff, b_ff, a_in, b_in;

   assign ac_in = a * cos_v;
   assign bs_in = b * sin_v;
   assign as_in = a * sin_v;
   assign bc_in = b * cos_v;

   always_comb begin
      sum_a = (PW+1)'(ac_ff) - (PW+1)'(bs_ff) + (PW+1)'(16384);
      sum_b = (PW+1)'(as_ff) + (PW+1)'(bc_ff) + (PW+1)'(16384);
      a_in  = lpp_pkg::CRD_BITS'(sum_a >>> 15);
      b_in  = lpp_pkg::CRD_BITS'(sum_b >>> 15);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ac_ff <= ac_in;
         bs_ff <= bs_in;
         as_ff <= as_in;
         bc_ff <= bc_in;
         a_ff  <= a_in;
         b_ff  <= b_in;
      end
   end

   assign a_rot = a_ff;
   assign b_rot = b_ff;

endmodule

FILE: sv/lpp_div_cell.sv
`timescale 1ns / 1ps
// One cell of the restoring divider chain: one quotient bit for each of the x and y lanes.
// Depends on lpp_pkg.
module lpp_div_cell #(
   parameter int NW = lpp_pkg::SCREEN_BITS_DEF + lpp_pkg::CRD_BITS - 1,
   parameter int DW = lpp_pkg::DEN_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  lpp_pkg::div_ctl_type up_ctl,
   input  logic [DW-1:0]        up_den,
   input  logic [DW-1:0]        up_rem_x,
   input  logic [NW-1:0]        up_nq_x,
   input  logic [DW-1:0]        up_rem_y,
   input  logic [NW-1:0]        up_nq_y,
   output lpp_pkg::div_ctl_type dn_ctl,
   output logic [DW-1:0]        dn_den,
   output logic [DW-1:0]        dn_rem_x,
   output logic [NW-1:0]        dn_nq_x,
   output logic [DW-1:0]        dn_rem_y,
   output logic [NW-1:0]        dn_nq_y
);

   logic [DW:0] sh_x, sh_y;
   logic        ge_x, ge_y;

   lpp_pkg::div_ctl_type ctl_ff;
   logic [DW-1:0] den_ff, rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [NW-1:0] nq_x_ff, nq_y_ff, nq_x_in, nq_y_in;

   // shift in the next numerator bit, subtract when it fits
   always_comb begin
      sh_x     = {up_rem_x, up_nq_x[NW-1]};
      sh_y     = {up_rem_y, up_nq_y[NW-1]};
      ge_x     = sh_x >= {1'b0, up_den};
      ge_y     = sh_y >= {1'b0, up_den};
      rem_x_in = ge_x ? DW'(sh_x - {1'b0, up_den}) : DW'(sh_x);
      rem_y_in = ge_y ? DW'(sh_y - {1'b0, up_den}) : DW'(sh_y);
      nq_x_in  = {up_nq_x[NW-2:0], ge_x};
      nq_y_in  = {up_nq_y[NW-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff   <= up_den;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         nq_x_ff  <= nq_x_in;
         nq_y_ff  <= nq_y_in;
      end
   end

   assign dn_ctl   = ctl_ff;
   assign dn_den   = den_ff;
   assign dn_rem_x = rem_x_ff;
   assign dn_rem_y = rem_y_ff;
   assign dn_nq_x  = nq_x_ff;
   assign dn_nq_y  = nq_y_ff;

endmodule

FILE: sv/lissajous_point_projector.sv
`timescale 1ns / 1ps
// Lissajous point projector top level; depends on lpp_pkg, lpp_req_if, lpp_rsp_if, lpp_sin,
// lpp_rotate and lpp_div_cell. Throughput: one transfer per cycle on both channels while the
// response queue is not full. A request passes 19 front stages, one divider cell per quotient
// bit and one queue write on its way to the response channel.
// Reset (synchronous, active high) empties the pipeline and the 2-entry response queue and
// loads the register defaults; rotation sines settle once the new angles have passed lpp_sin.
module lissajous_point_projector #(
   parameter int ANGLE_BITS  = lpp_pkg::ANGLE_BITS_DEF,
   parameter int SCREEN_BITS = lpp_pkg::SCREEN_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lpp_req_if.sink                               req_ch,
   lpp_rsp_if.source                             rsp_ch,
   input  logic                                  csr_we,
   input  logic [lpp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [lpp_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int CW       = lpp_pkg::CRD_BITS;
   localparam int DW       = lpp_pkg::DEN_BITS;
   localparam int NUM_BITS = SCREEN_BITS + CW + 1;   // signed width * coordinate
   localparam int NW       = NUM_BITS - 2;           // quotient magnitude bits = divider cells
   localparam int SUM_BITS = NW + 2;
   localparam int FRONT    = 19;                     // stages ahead of the divider chain
   localparam int ST_PERSP = FRONT - 1;
   localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
   localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'(32767);
   localparam logic signed [SUM_BITS-1:0] SAT_LO = SUM_BITS'(-32768);

   // 16-bit turn fraction taken to ANGLE_BITS, keeping the high bits
   function automatic logic [ANGLE_BITS-1:0] turn_frac(input logic [15:0] f);
      logic [23:0] w24;
      w24 = {f, 8'b0};
      return w24[23 -: ANGLE_BITS];
   endfunction

   // ---------------------------------------------------------------- configuration registers
   logic [47:0]            freq_ff;
   logic [31:0]            phase_ff;
   logic [47:0]            rot_ff;
   logic [35:0]            amp_ff;
   logic [14:0]            dist_ff;
   logic [SCREEN_BITS-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff   <= lpp_pkg::FREQ_RST;
         phase_ff  <= lpp_pkg::PHASE_RST;
         rot_ff    <= lpp_pkg::ROT_RST;
         amp_ff    <= lpp_pkg::AMP_RST;
         dist_ff   <= lpp_pkg::DIST_RST;
         width_ff  <= SCREEN_BITS'(lpp_pkg::WIDTH_RST);
         height_ff <= SCREEN_BITS'(lpp_pkg::HEIGHT_RST);
      end else if (csr_we) begin
         case (csr_index)
            lpp_pkg::REG_FREQUENCIES: freq_ff   <= csr_data[47:0];
            lpp_pkg::REG_PHASES:      phase_ff  <= csr_data[31:0];
            lpp_pkg::REG_ROTATIONS:   rot_ff    <= csr_data[47:0];
            lpp_pkg::REG_AMPLITUDES:  amp_ff    <= csr_data[35:0];
            lpp_pkg::REG_DISTANCE:    dist_ff   <= csr_data[14:0];
            lpp_pkg::REG_WIDTH:       width_ff  <= csr_data[SCREEN_BITS-1:0];
            lpp_pkg::REG_HEIGHT:      height_ff <= csr_data[SCREEN_BITS-1:0];
            default: ;   // drop writes to unknown indexes
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // The whole pipeline advances together; it stalls only when the response queue is full,
   // so requests keep flowing while a finished point waits for its transfer.
   logic       en;
   logic       accept;
   logic [1:0] cnt_ff, cnt_in;
   logic [FRONT-1:0] vld_ff, vld_in;

   assign en            = (cnt_ff != 2'd2);
   assign req_ch.ready  = en;
   assign accept        = req_ch.valid && en;
   assign vld_in        = {vld_ff[FRONT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------- rotation trig
   // Depends on configuration only; free-running.
   logic [ANGLE_BITS-1:0] rot_ang [3];
   logic signed [lpp_pkg::TRIG_BITS-1:0] rot_cos [3];
   logic signed [lpp_pkg::TRIG_BITS-1:0] rot_sin [3];

   for (genvar k = 0; k < 3; k++) begin : g_rot_trig
      assign rot_ang[k] = turn_frac(rot_ff[16*k +: 16]);
      lpp_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_r (
         .clock(clock), .en(1'b1), .angle(rot_ang[k]), .sin_q15(rot_sin[k]));
      lpp_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos_r (
         .clock(clock), .en(1'b1), .angle(ANGLE_BITS'(rot_ang[k] + QTR)), .sin_q15(rot_cos[k]));
   end

   // ---------------------------------------------------------------- curve point
   logic [lpp_pkg::SAMPLE_BITS-1:0] t_ff;
   logic [ANGLE_BITS-1:0] ph [3];
   logic [32:0] wt_ff [3];
   logic [54:0] p_ff  [3], p_in [3];
   logic [ANGLE_BITS-1:0] ang_ff [3], ang_in [3];
   logic signed [lpp_pkg::TRIG_BITS-1:0] cos_c [3];
   logic signed [28:0] ampp_ff [3], ampp_in [3];
   logic signed [CW-1:0] crd_ff [3], crd_in [3];

   assign ph[0] = '0;
   assign ph[1] = turn_frac(phase_ff[15:0]);
   assign ph[2] = turn_frac(phase_ff[31:16]);

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= req_ch.sample_time;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_curve
      // angle in turns = w*t/(2*pi); keep the turn-fraction bits only
      always_comb begin
         p_in[k]    = 55'(55'(wt_ff[k][31:0]) * 55'(lpp_pkg::INV2PI))
                    + (wt_ff[k][32] ? (55'(lpp_pkg::INV2PI) << 32) : 55'd0);
         ang_in[k]  = ANGLE_BITS'(p_ff[k][54 -: ANGLE_BITS] + ph[k] + QTR);
         ampp_in[k] = $signed({1'b0, amp_ff[12*k +: 12]}) * cos_c[k];
         crd_in[k]  = CW'((ampp_ff[k] + 29'sd64) >>> 7);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            wt_ff[k]   <= 33'(freq_ff[16*k +: 16]) * 33'(t_ff);
            p_ff[k]    <= p_in[k];
            ang_ff[k]  <= ang_in[k];
            ampp_ff[k] <= ampp_in[k];
            crd_ff[k]  <= crd_in[k];
         end
      end

      lpp_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos_c (
         .clock(clock), .en(en), .angle(ang_ff[k]), .sin_q15(cos_c[k]));
   end

   // ---------------------------------------------------------------- rotations x, y, z
   logic signed [CW-1:0] y1, z1, z2, x2, x3, y3;
   logic signed [CW-1:0] xd_ff [2], y1d_ff [2], z2d_ff [2];

   lpp_rotate u_rot_x (.clock(clock), .en(en), .cos_v(rot_cos[0]), .sin_v(rot_sin[0]),
      .a(crd_ff[1]), .b(crd_ff[2]), .a_rot(y1), .b_rot(z1));
   lpp_rotate u_rot_y (.clock(clock), .en(en), .cos_v(rot_cos[1]), .sin_v(rot_sin[1]),
      .a(z1), .b(xd_ff[1]), .a_rot(z2), .b_rot(x2));
   lpp_rotate u_rot_z (.clock(clock), .en(en), .cos_v(rot_cos[2]), .sin_v(rot_sin[2]),
      .a(x2), .b(y1d_ff[1]), .a_rot(x3), .b_rot(y3));

   // hold the coordinate that bypasses each rotation for its two stages
   always_ff @(posedge clock) begin
      if (en) begin
         xd_ff[0]  <= crd_ff[0];
         xd_ff[1]  <= xd_ff[0];
         y1d_ff[0] <= y1;
         y1d_ff[1] <= y1d_ff[0];
         z2d_ff[0] <= z2;
         z2d_ff[1] <= z2d_ff[0];
      end
   end

   // ---------------------------------------------------------------- perspective setup
   logic signed [DW:0]         den_s;
   logic signed [NUM_BITS-1:0] numx_ff, numy_ff, numx_in, numy_in;
   logic signed [NUM_BITS-1:0] magx_full, magy_full;
   logic [DW-1:0]              den_ff;
   logic                       behind_ff, behind_in;

   always_comb begin
      den_s     = $signed({2'b00, dist_ff, 8'b0}) + (DW+1)'(z2d_ff[1]);
      behind_in = den_s[DW] || (den_s == '0);
      numx_in   = $signed({1'b0, width_ff}) * x3;
      numy_in   = $signed({1'b0, width_ff}) * y3;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff    <= den_s[DW-1:0];
         behind_ff <= behind_in;
         numx_ff   <= numx_in;
         numy_ff   <= numy_in;
      end
   end

   // ---------------------------------------------------------------- divider chain
   // Restoring division of |width*coord| by the denominator, one quotient bit per cell,
   // truncated toward zero; sign restored at the end.
   lpp_pkg::div_ctl_type ctl_w [NW+1];
   logic [DW-1:0] den_w   [NW+1];
   logic [DW-1:0] rem_x_w [NW+1];
   logic [DW-1:0] rem_y_w [NW+1];
   logic [NW-1:0] nq_x_w  [NW+1];
   logic [NW-1:0] nq_y_w  [NW+1];

   always_comb begin
      magx_full        = numx_ff[NUM_BITS-1] ? -numx_ff : numx_ff;
      magy_full        = numy_ff[NUM_BITS-1] ? -numy_ff : numy_ff;
      ctl_w[0].valid   = vld_ff[ST_PERSP];
      ctl_w[0].behind  = behind_ff;
      ctl_w[0].neg_x   = numx_ff[NUM_BITS-1];
      ctl_w[0].neg_y   = numy_ff[NUM_BITS-1];
      den_w[0]         = den_ff;
      rem_x_w[0]       = '0;
      rem_y_w[0]       = '0;
      nq_x_w[0]        = magx_full[NW-1:0];
      nq_y_w[0]        = magy_full[NW-1:0];
   end

   for (genvar k = 0; k < NW; k++) begin : g_div
      lpp_div_cell #(.NW(NW), .DW(DW)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .up_ctl(ctl_w[k]), .up_den(den_w[k]),
         .up_rem_x(rem_x_w[k]), .up_nq_x(nq_x_w[k]),
         .up_rem_y(rem_y_w[k]), .up_nq_y(nq_y_w[k]),
         .dn_ctl(ctl_w[k+1]), .dn_den(den_w[k+1]),
         .dn_rem_x(rem_x_w[k+1]), .dn_nq_x(nq_x_w[k+1]),
         .dn_rem_y(rem_y_w[k+1]), .dn_nq_y(nq_y_w[k+1]));
   end

   // ---------------------------------------------------------------- screen offset, saturate
   logic signed [NW:0]         qx, qy;
   logic signed [SUM_BITS-1:0] sum_x, sum_y;
   lpp_pkg::rsp_payload_type   fin;

   always_comb begin
      qx    = ctl_w[NW].neg_x ? -$signed({1'b0, nq_x_w[NW]}) : $signed({1'b0, nq_x_w[NW]});
      qy    = ctl_w[NW].neg_y ? -$signed({1'b0, nq_y_w[NW]}) : $signed({1'b0, nq_y_w[NW]});
      sum_x = SUM_BITS'($signed({1'b0, width_ff[SCREEN_BITS-1:1]})) + SUM_BITS'(qx);
      sum_y = SUM_BITS'($signed({1'b0, height_ff[SCREEN_BITS-1:1]})) - SUM_BITS'(qy);
      if (sum_x > SAT_HI)      fin.screen_x = 16'sh7FFF;
      else if (sum_x < SAT_LO) fin.screen_x = -16'sh8000;
      else                     fin.screen_x = sum_x[15:0];
      if (sum_y > SAT_HI)      fin.screen_y = 16'sh7FFF;
      else if (sum_y < SAT_LO) fin.screen_y = -16'sh8000;
      else                     fin.screen_y = sum_y[15:0];
      fin.behind_viewer = ctl_w[NW].behind;
      if (ctl_w[NW].behind) begin
         fin.screen_x = '0;   // point behind the viewer: report zeros
         fin.screen_y = '0;
      end
   end

   // ---------------------------------------------------------------- response queue
   logic                     push, pop;
   logic                     wr_ff, rd_ff;
   lpp_pkg::rsp_payload_type q_ff [2];

   assign push   = en && ctl_w[NW].valid;
   assign pop    = (cnt_ff != 2'd0) && rsp_ch.ready;
   assign cnt_in = 2'(cnt_ff + 2'(push) - 2'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= fin;
      end
   end

   assign rsp_ch.valid         = (cnt_ff != 2'd0);
   assign rsp_ch.screen_x      = q_ff[rd_ff].screen_x;
   assign rsp_ch.screen_y      = q_ff[rd_ff].screen_y;
   assign rsp_ch.behind_viewer = q_ff[rd_ff].behind_viewer;

endmodule

FILE: sv/lpp_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the Lissajous point projector, bound to the top level.
// Depends on lissajous_point_projector and lpp_pkg.
module lpp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [lpp_pkg::OUT_BITS-1:0] screen_x,
   input logic signed [lpp_pkg::OUT_BITS-1:0] screen_y,
   input logic                                behind_viewer
);

   // a point behind the viewer always reports the origin
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && behind_viewer |-> screen_x == '0 && screen_y == '0)
      else $error("behind_viewer point with nonzero coordinates");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an empty output side never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no response pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped without transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(screen_x) && $stable(screen_y)
                                  && $stable(behind_viewer))
      else $error("response payload changed while stalled");

endmodule

bind lissajous_point_projector lpp_checker u_lpp_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .screen_x(rsp_ch.screen_x),
   .screen_y(rsp_ch.screen_y),
   .behind_viewer(rsp_ch.behind_viewer)
);
